// ----- hdl/pse_pkg.sv -----
package pse_pkg;

    // Default sizes of the operand stack and of its entries
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int DEFAULT_DATA_WIDTH  = 32;

    // Fixed port widths
    localparam int NUMBER_WIDTH = 31;
    localparam int RESULT_WIDTH = 32;
    localparam int STATUS_WIDTH = 3;

    typedef enum logic {
        KIND_NUMBER   = 1'b0,
        KIND_OPERATOR = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_OVERFLOW  = 3'd2,
        STAT_DIVZERO   = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_WAIT,
        S_FIN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    tok_load;   // capture the token on an input transfer
        logic    push;       // push the number token
        logic    err_load;   // record an error code
        status_t err_code;
        logic    rd_issue;   // read the entry below top of stack
        logic    wr_alu;     // write add/subtract result, pop one
        logic    start_md;   // start the multiply/divide unit
        logic    wr_md;      // write multiply/divide result, pop one
        logic    emit;       // load the output register, clear the stack
    } pse_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        kind_t tok_kind;
        op_t   tok_op;
        logic  tok_last;
        logic  err_active;
        logic  full;
        logic  lt2;
        logic  b_zero;
        logic  md_done;
        logic  out_free;
    } pse_stat_t;

endpackage

// ----- hdl/pse_muldiv.sv -----
module pse_muldiv #(
    parameter int DATA_WIDTH = pse_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  is_div,
    input  logic [DATA_WIDTH-1:0] opnd_a,
    input  logic [DATA_WIDTH-1:0] opnd_b,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] result
);
    import pse_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  div_reg, div_next;
    logic                  neg_reg, neg_next;
    logic [DATA_WIDTH:0]   acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] work_reg, work_next;
    logic [DATA_WIDTH-1:0] opnd_reg, opnd_next;

    logic [DATA_WIDTH-1:0] a_mag, b_mag;
    logic [DATA_WIDTH:0]   rem_shift, trial;
    logic [DATA_WIDTH-1:0] addend;

    // Operand magnitudes for the divide (most negative maps to itself, unsigned)
    assign a_mag = opnd_a[DATA_WIDTH-1] ? (~opnd_a + 1'b1) : opnd_a;
    assign b_mag = opnd_b[DATA_WIDTH-1] ? (~opnd_b + 1'b1) : opnd_b;

    // One restoring-division step and one shift-add step
    assign rem_shift = {acc_reg[DATA_WIDTH-1:0], work_reg[DATA_WIDTH-1]};
    assign trial     = rem_shift - {1'b0, opnd_reg};
    assign addend    = work_reg[0] ? opnd_reg : '0;

    // Next-value logic
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        work_next = work_reg;
        opnd_next = opnd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_WIDTH);
            div_next  = is_div;
            neg_next  = opnd_a[DATA_WIDTH-1] ^ opnd_b[DATA_WIDTH-1];
            acc_next  = '0;
            work_next = is_div ? a_mag : opnd_b;
            opnd_next = is_div ? b_mag : opnd_a;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg) begin
                if (!trial[DATA_WIDTH]) begin
                    acc_next  = trial;
                    work_next = {work_reg[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    acc_next  = rem_shift;
                    work_next = {work_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end else begin
                acc_next  = {1'b0, acc_reg[DATA_WIDTH-1:0] + addend};
                opnd_next = {opnd_reg[DATA_WIDTH-2:0], 1'b0};
                work_next = {1'b0, work_reg[DATA_WIDTH-1:1]};
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial-result registers
    always_ff @(posedge aclk) begin
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        work_reg <= work_next;
        opnd_reg <= opnd_next;
    end

    assign done   = done_reg;
    assign result = div_reg ? (neg_reg ? (~work_reg + 1'b1) : work_reg)
                            : acc_reg[DATA_WIDTH-1:0];

endmodule

// ----- hdl/pse_datapath.sv -----
module pse_datapath #(
    parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH,
    parameter int DATA_WIDTH  = pse_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pse_pkg::pse_cmd_t                    cmd,
    output pse_pkg::pse_stat_t                   stat,
    input  logic                                 s_req_type,
    input  logic [pse_pkg::NUMBER_WIDTH-1:0]     s_number_value,
    input  logic [1:0]                           s_operator_code,
    input  logic                                 s_last_token,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pse_pkg::RESULT_WIDTH-1:0] m_result_value,
    output logic [pse_pkg::STATUS_WIDTH-1:0]     m_status
);
    import pse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Entries below top of stack; top lives in tos_reg
    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];

    kind_t                   tok_kind_reg;
    logic [NUMBER_WIDTH-1:0] tok_num_reg;
    op_t                     tok_op_reg;
    logic                    tok_last_reg;

    logic [DATA_WIDTH-1:0]   tos_reg, tos_next;
    logic [DATA_WIDTH-1:0]   rd_data_reg;
    logic [CW-1:0]           count_reg, count_next;
    status_t                 err_reg, err_next;

    logic                    m_valid_reg, m_valid_next;
    logic [RESULT_WIDTH-1:0] m_result_reg;
    status_t                 m_status_reg;

    logic [CW-1:0]           count_m1, count_m2;
    logic [DATA_WIDTH+NUMBER_WIDTH-1:0] num_wide;
    logic [DATA_WIDTH+RESULT_WIDTH-1:0] tos_ext;
    logic [DATA_WIDTH-1:0]   num_val, alu_res, md_res;
    logic                    md_done;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign num_wide = {{DATA_WIDTH{1'b0}}, tok_num_reg};
    assign num_val  = num_wide[DATA_WIDTH-1:0];
    assign tos_ext  = {{RESULT_WIDTH{tos_reg[DATA_WIDTH-1]}}, tos_reg};
    assign alu_res  = (tok_op_reg == OP_SUB) ? (rd_data_reg - tos_reg)
                                             : (rd_data_reg + tos_reg);

    // Iterative multiply/divide: first operand from memory, second is top
    pse_muldiv #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_md),
        .is_div  (tok_op_reg == OP_DIV),
        .opnd_a  (rd_data_reg),
        .opnd_b  (tos_reg),
        .done    (md_done),
        .result  (md_res)
    );

    // Token capture on an input transfer
    always_ff @(posedge aclk) begin
        if (cmd.tok_load) begin
            tok_kind_reg <= kind_t'(s_req_type);
            tok_num_reg  <= s_number_value;
            tok_op_reg   <= op_t'(s_operator_code);
            tok_last_reg <= s_last_token;
        end
    end

    // Stack memory: push spills the old top, operator reads the entry below
    always_ff @(posedge aclk) begin
        if (cmd.push && (count_reg != '0)) begin
            mem[count_m1[AW-1:0]] <= tos_reg;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[count_m2[AW-1:0]];
        end
    end

    // Top of stack, fill count and sticky error
    always_comb begin
        tos_next   = tos_reg;
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.push) begin
            tos_next   = num_val;
            count_next = count_reg + CW'(1);
        end
        if (cmd.wr_alu) begin
            tos_next   = alu_res;
            count_next = count_m1;
        end
        if (cmd.wr_md) begin
            tos_next   = md_res;
            count_next = count_m1;
        end
        if (cmd.err_load) begin
            err_next = cmd.err_code;
        end
        if (cmd.emit) begin
            count_next = '0;
            err_next   = STAT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg <= tos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            err_reg   <= STAT_OK;
        end else begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    // Output register: loading wins over a transfer in the same cycle
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (err_reg != STAT_OK) begin
                m_result_reg <= '0;
                m_status_reg <= err_reg;
            end else if (count_reg == '0) begin
                m_result_reg <= '0;
                m_status_reg <= STAT_EMPTY;
            end else begin
                m_result_reg <= tos_ext[RESULT_WIDTH-1:0];
                m_status_reg <= STAT_OK;
            end
        end
    end

    // Status to the controller
    always_comb begin
        stat.tok_kind   = tok_kind_reg;
        stat.tok_op     = tok_op_reg;
        stat.tok_last   = tok_last_reg;
        stat.err_active = (err_reg != STAT_OK);
        stat.full       = (count_reg == CW'(STACK_DEPTH));
        stat.lt2        = (count_reg < CW'(2));
        stat.b_zero     = (tos_reg == '0);
        stat.md_done    = md_done;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_status       = m_status_reg;

endmodule

// ----- hdl/pse_ctrl.sv -----
module pse_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pse_pkg::pse_stat_t  stat,
    output pse_pkg::pse_cmd_t   cmd
);
    import pse_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!stat.err_active && (stat.tok_kind == KIND_OPERATOR) && !stat.lt2) begin
                    state_next = S_EXEC;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_EXEC: begin
                if ((stat.tok_op == OP_MUL)
                    || ((stat.tok_op == OP_DIV) && !stat.b_zero)) begin
                    state_next = S_WAIT;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_WAIT: begin
                if (stat.md_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!stat.tok_last || stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.tok_load = s_valid;
            end
            S_DECODE: begin
                if (!stat.err_active) begin
                    if (stat.tok_kind == KIND_NUMBER) begin
                        if (stat.full) begin
                            cmd.err_load = 1'b1;
                            cmd.err_code = STAT_OVERFLOW;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end else if (stat.lt2) begin
                        cmd.err_load = 1'b1;
                        cmd.err_code = STAT_UNDERFLOW;
                    end else begin
                        cmd.rd_issue = 1'b1;
                    end
                end
            end
            S_EXEC: begin
                if ((stat.tok_op == OP_DIV) && stat.b_zero) begin
                    cmd.err_load = 1'b1;
                    cmd.err_code = STAT_DIVZERO;
                end else if ((stat.tok_op == OP_ADD) || (stat.tok_op == OP_SUB)) begin
                    cmd.wr_alu = 1'b1;
                end else begin
                    cmd.start_md = 1'b1;
                end
            end
            S_WAIT: begin
                cmd.wr_md = stat.md_done;
            end
            S_FIN: begin
                cmd.emit = stat.tok_last && stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hdl/postfix_stack_evaluator.sv -----
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    req_type, number_value, operator_code, last_token
// m_       out        m_valid/m_ready    result_value, status
//
// One token at a time: a number is decoded and pushed, an add or subtract is decoded and
// executed; a multiply or divide then waits for the bit-serial multiply/divide unit.
// The final token waits in the finish state until the output register is free.
// aresetn is synchronous, active low; it empties the stack and drops any pending result.
// A stalled m_ready holds only a final token; other tokens keep flowing.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::DEFAULT_STACK_DEPTH,
    parameter int DATA_WIDTH  = pse_pkg::DEFAULT_DATA_WIDTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_req_type,
    input  logic [pse_pkg::NUMBER_WIDTH-1:0]        s_number_value,
    input  logic [1:0]                              s_operator_code,
    input  logic                                    s_last_token,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [pse_pkg::RESULT_WIDTH-1:0] m_result_value,
    output logic [pse_pkg::STATUS_WIDTH-1:0]        m_status
);
    import pse_pkg::*;

    pse_cmd_t  cmd;
    pse_stat_t stat;

    // Sequencer
    pse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Stack, arithmetic and output register
    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_req_type      (s_req_type),
        .s_number_value  (s_number_value),
        .s_operator_code (s_operator_code),
        .s_last_token    (s_last_token),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_status        (m_status)
    );

endmodule

// ----- sim/postfix_stack_evaluator_test.sv -----
`timescale 1ns / 100ps

import pse_pkg::*;

// Tracks the operand stack of the block and queues the result of each final token
class rpn_scoreboard;
    localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;

    logic [RESULT_WIDTH-1:0] operands[STACK_DEPTH];
    int unsigned             depth;
    status_t                 sticky;
    logic [RESULT_WIDTH-1:0] result_value_q[$];
    status_t                 status_q[$];
    int                      errors;

    function new();
        depth  = 0;
        sticky = STAT_OK;
        errors = 0;
    endfunction

    task report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function int pending();
        return result_value_q.size();
    endfunction

    // Appends one expected result at the tail of the queues
    function void queue_result(logic [RESULT_WIDTH-1:0] value, status_t status);
        result_value_q.insert(result_value_q.size(), value);
        status_q.insert(status_q.size(), status);
    endfunction

    // Signed 32-bit arithmetic; divide truncates toward zero, min / -1 wraps
    function logic [RESULT_WIDTH-1:0] evaluate(op_t op, logic [RESULT_WIDTH-1:0] a,
                                               logic [RESULT_WIDTH-1:0] b);
        logic [RESULT_WIDTH-1:0] mag_a, mag_b, quot;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_MUL: return a * b;
            default: begin
                mag_a = a[RESULT_WIDTH-1] ? -a : a;
                mag_b = b[RESULT_WIDTH-1] ? -b : b;
                quot  = mag_a / mag_b;
                return (a[RESULT_WIDTH-1] != b[RESULT_WIDTH-1]) ? -quot : quot;
            end
        endcase
    endfunction

    // Applies one accepted token; returns 1 if the token was evaluated, 0 if ignored
    function bit note_token(kind_t kind, logic [NUMBER_WIDTH-1:0] num, op_t op, logic last);
        logic [RESULT_WIDTH-1:0] a, b;
        bit                      acted;
        acted = (sticky == STAT_OK);
        if (acted) begin
            if (kind == KIND_NUMBER) begin
                if (depth < STACK_DEPTH) begin
                    operands[depth] = {1'b0, num};
                    depth++;
                end else begin
                    sticky = STAT_OVERFLOW;
                end
            end else if (depth < 2) begin
                sticky = STAT_UNDERFLOW;
            end else begin
                b = operands[depth-1];
                a = operands[depth-2];
                if (op == OP_DIV && b == '0) begin
                    sticky = STAT_DIVZERO;
                end else begin
                    operands[depth-2] = evaluate(op, a, b);
                    depth--;
                end
            end
        end
        // final token: emit top of stack or the error, then start over
        if (last) begin
            if (sticky != STAT_OK) begin
                queue_result({RESULT_WIDTH{1'b0}}, sticky);
            end else if (depth == 0) begin
                queue_result({RESULT_WIDTH{1'b0}}, STAT_EMPTY);
            end else begin
                queue_result(operands[depth-1], STAT_OK);
            end
            depth  = 0;
            sticky = STAT_OK;
        end
        return acted;
    endfunction

    task check_result(logic [RESULT_WIDTH-1:0] value, logic [STATUS_WIDTH-1:0] status);
        logic [RESULT_WIDTH-1:0] exp_value;
        status_t                 exp_status;
        if (result_value_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d status %0d",
                                      $signed(value), status));
        end else begin
            exp_value  = result_value_q.pop_front();
            exp_status = status_q.pop_front();
            if (value !== exp_value)
                report_mismatch($sformatf("result_value %0d, expected %0d",
                                          $signed(value), $signed(exp_value)));
            if (status !== exp_status)
                report_mismatch($sformatf("status %0d, expected %0d", status, exp_status));
        end
    endtask
endclass

module postfix_stack_evaluator_test;

    localparam int STACK_DEPTH    = DEFAULT_STACK_DEPTH;
    localparam int TOKEN_TARGET   = 1650;
    localparam int QUIET_TOKENS   = 700;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic                     s_req_type      = 1'b0;
    logic [NUMBER_WIDTH-1:0]  s_number_value  = '0;
    logic [1:0]               s_operator_code = '0;
    logic                     s_last_token    = 1'b0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic signed [RESULT_WIDTH-1:0] m_result_value;
    logic [STATUS_WIDTH-1:0]  m_status;

    rpn_scoreboard sb = new();
    bit            idle_en = 1'b1;
    int            evaluated = 0;
    int            stall_cycles = 0;

    postfix_stack_evaluator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_number_value  (s_number_value),
        .s_operator_code (s_operator_code),
        .s_last_token    (s_last_token),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_status        (m_status)
    );

    always #5 aclk = ~aclk;

    // Result side: check each transfer, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_result_value, m_status);
            m_ready <= !idle_en || ($urandom_range(99) >= 20);
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("[postfix_stack_evaluator] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // One token transfer, with optional idle cycles before it
    task send_token(kind_t kind, logic [NUMBER_WIDTH-1:0] num, op_t op, logic last);
        while (idle_en && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= kind;
        s_number_value  <= num;
        s_operator_code <= op;
        s_last_token    <= last;
        do @(posedge aclk); while (!s_ready);
        if (sb.note_token(kind, num, op, last))
            evaluated++;
    endtask

    task push_number(logic [NUMBER_WIDTH-1:0] num, logic last);
        send_token(KIND_NUMBER, num, op_t'($urandom_range(3)), last);
    endtask

    task apply_operator(op_t op, logic last);
        send_token(KIND_OPERATOR, NUMBER_WIDTH'($urandom), op, last);
    endtask

    // Operand values biased toward zero, one and the largest value
    function logic [NUMBER_WIDTH-1:0] pick_number();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 1;
            2:       return {NUMBER_WIDTH{1'b1}};
            3:       return NUMBER_WIDTH'($urandom_range(15));
            4, 5:    return NUMBER_WIDTH'($urandom_range(1000));
            default: return NUMBER_WIDTH'($urandom);
        endcase
    endfunction

    // Valid postfix expression, never deeper than max_depth; sometimes leaves extra operands
    task well_formed(int max_depth, int pushes, bit greedy);
        int depth, left, final_depth, next_depth;
        bit is_push, done;
        depth       = 0;
        left        = pushes;
        final_depth = ($urandom_range(7) == 0) ? $urandom_range(1, (pushes < 3) ? pushes : 3) : 1;
        done        = 1'b0;
        while (!done) begin
            if (depth < 2)
                is_push = 1'b1;
            else if (left == 0 || depth == max_depth)
                is_push = 1'b0;
            else
                is_push = greedy || $urandom_range(1);
            if (is_push) begin
                left--;
                next_depth = depth + 1;
            end else begin
                next_depth = depth - 1;
            end
            done = (left == 0 && next_depth <= final_depth);
            if (is_push)
                push_number(pick_number(), done);
            else
                apply_operator(op_t'($urandom_range(3)), done);
            depth = next_depth;
        end
    endtask

    // Arbitrary tokens; the last one always closes the expression
    task noise_tokens(int count);
        logic last;
        for (int i = 0; i < count; i++) begin
            last = (i == count - 1) || ($urandom_range(7) == 0);
            if ($urandom_range(1))
                push_number(pick_number(), last);
            else
                apply_operator(op_t'($urandom_range(3)), last);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // largest operand alone
        push_number({NUMBER_WIDTH{1'b1}}, 1'b1);
        // operator on an empty stack
        apply_operator(OP_ADD, 1'b1);
        // divide by zero
        push_number(7, 1'b0);
        push_number(0, 1'b0);
        apply_operator(OP_DIV, 1'b1);
        // most negative over minus one wraps
        push_number({NUMBER_WIDTH{1'b1}}, 1'b0);
        push_number(1, 1'b0);
        apply_operator(OP_ADD, 1'b0);
        push_number(0, 1'b0);
        push_number(1, 1'b0);
        apply_operator(OP_SUB, 1'b0);
        apply_operator(OP_DIV, 1'b1);
        // multiply wrap, truncating divide of a negative, leftover operands
        push_number({NUMBER_WIDTH{1'b1}}, 1'b0);
        push_number({NUMBER_WIDTH{1'b1}}, 1'b0);
        apply_operator(OP_MUL, 1'b0);
        push_number(0, 1'b0);
        push_number(7, 1'b0);
        apply_operator(OP_SUB, 1'b0);
        push_number(2, 1'b0);
        apply_operator(OP_DIV, 1'b1);
        // underflow, then later tokens of the expression are ignored
        push_number(9, 1'b0);
        apply_operator(OP_MUL, 1'b0);
        push_number(2, 1'b0);
        push_number(3, 1'b0);
        apply_operator(OP_ADD, 1'b1);

        // random expressions: first a stretch with no idling
        idle_en = 1'b0;
        while (evaluated < TOKEN_TARGET) begin
            case ($urandom_range(9))
                0: well_formed(STACK_DEPTH, STACK_DEPTH + $urandom_range(4), 1'b1);
                1: begin
                    // overflow, then some ignored tokens
                    repeat (STACK_DEPTH + 1 + $urandom_range(2))
                        push_number(pick_number(), 1'b0);
                    noise_tokens($urandom_range(1, 4));
                end
                2: noise_tokens($urandom_range(1, 8));
                default: well_formed($urandom_range(2, STACK_DEPTH), $urandom_range(1, 6), 1'b0);
            endcase
            if (evaluated >= QUIET_TOKENS)
                idle_en = 1'b1;
        end
        s_valid <= 1'b0;

        // drain outstanding results
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("[postfix_stack_evaluator] OK");
        else
            $display("[postfix_stack_evaluator] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pse_pkg.sv
hdl/pse_muldiv.sv
hdl/pse_datapath.sv
hdl/pse_ctrl.sv
hdl/postfix_stack_evaluator.sv
sim/postfix_stack_evaluator_test.sv
